@@ rtl/rcc_pkg.sv @@
// Shared types and constants for the RGB 3x3 convolution core.
package rcc_pkg;

  localparam int unsigned MaxWidthDef = 1024;
  localparam int unsigned MaxHeight   = 4096;
  localparam int unsigned FracBits    = 12;
  localparam int unsigned AccW        = 28;
  localparam int unsigned NumTaps     = 9;
  localparam int unsigned PixW        = 24;
  localparam int unsigned TapW        = 16;
  localparam int unsigned RowW        = 13;

  localparam logic [AccW-1:0] RoundHalf   = AccW'(2048);
  localparam logic [47:0]     KTopRst     = 48'd0;
  localparam logic [47:0]     KMidRst     = 48'd268435456;
  localparam logic [47:0]     KBotRst     = 48'd0;
  localparam logic [10:0]     FWidthRst   = 11'd1024;
  localparam logic [12:0]     FHeightRst  = 13'd768;

  typedef enum logic [2:0] {
    CFG_KTOP    = 3'd0,
    CFG_KMID    = 3'd1,
    CFG_KBOT    = 3'd2,
    CFG_FWIDTH  = 3'd3,
    CFG_FHEIGHT = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef struct packed {
    logic vld;
    logic last;
  } ctl_t;

  typedef logic [NumTaps-1:0][PixW-1:0] pix9_t;
  typedef logic [2:0][AccW-1:0]         acc3_t;

endpackage

@@ rtl/rcc_tap_cell.sv @@
// One tap cell of the multiply-accumulate chain: adds tap times pixel per channel.
module rcc_tap_cell
  import rcc_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic signed [TapW-1:0] tap_i,
  input  ctl_t                   ctl_i,
  input  pix9_t                  pix_i,
  input  acc3_t                  acc_i,
  output ctl_t                   ctl_o,
  output pix9_t                  pix_o,
  output acc3_t                  acc_o
);

  ctl_t  ctl_q;
  pix9_t pix_q;
  acc3_t acc_q, acc_d;

  always_comb begin
    logic signed [TapW+8:0] prod;
    logic [7:0]             px;
    for (int ch = 0; ch < 3; ch++) begin
      px   = pix_i[Idx][16-8*ch +: 8];
      prod = tap_i * $signed({1'b0, px});
      acc_d[ch] = AccW'($signed(acc_i[ch]) + prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_q <= pix_i;
      acc_q <= acc_d;
    end
  end

  assign ctl_o = ctl_q;
  assign pix_o = pix_q;
  assign acc_o = acc_q;

endmodule

@@ rtl/rgb_conv3x3_clamp_edge_core.sv @@
// Top level of the RGB 3x3 convolution core with replicated frame borders.
//
//  channel | signals                                         | moves
//  --------+-------------------------------------------------+----------------------
//  in      | in_valid_i/in_ready_o, op_i, red/green/blue_in_i | one pixel or drain word
//  out     | out_valid_o/out_ready_i, *_out_o, frame_end_o    | one filtered pixel word
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i                 | one register write
//
// Takes one word per cycle while the output is not stalled. A result is built
// in order by the line store read at the accepting edge, the window update and
// tap select, nine tap cells and the saturating output register.
// A stalled output register freezes the whole pipe and drops in_ready_o.
// Reset clears counters, window and pipe valids; line stores start unknown.
module rgb_conv3x3_clamp_edge_core
  import rcc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MaxWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic        frame_end_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

  // Configuration registers
  logic [47:0] ktop_q, kmid_q, kbot_q;
  logic [10:0] fwidth_q;
  logic [12:0] fheight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ktop_q    <= KTopRst;
      kmid_q    <= KMidRst;
      kbot_q    <= KBotRst;
      fwidth_q  <= FWidthRst;
      fheight_q <= FHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KTOP:    ktop_q    <= cfg_data_i;
        CFG_KMID:    kmid_q    <= cfg_data_i;
        CFG_KBOT:    kbot_q    <= cfg_data_i;
        CFG_FWIDTH:  fwidth_q  <= cfg_data_i[10:0];
        CFG_FHEIGHT: fheight_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // Effective geometry: zero means one, clamp to the store depth / max rows
  logic [WW-1:0]   w_eff;
  logic [RowW-1:0] h_eff;

  always_comb begin
    if (fwidth_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(fwidth_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fwidth_q);
    end
    if (fheight_q == '0) begin
      h_eff = RowW'(1);
    end else if (32'(fheight_q) > MaxHeight) begin
      h_eff = RowW'(MaxHeight);
    end else begin
      h_eff = fheight_q;
    end
  end

  logic en;
  logic accept;

  // Input side position state
  logic [WW-1:0]   in_col_q, out_col_q;
  logic [RowW-1:0] in_row_q, out_row_q;
  logic [AW-1:0]   wp_q;
  logic            fdone_q;

  logic            is_pix, start, push, emit, fd_eff;
  logic            col_wrap, row_wrap, n_ge;
  logic            at_top, at_bot, at_left, at_right, last;
  logic [WW-1:0]   ox;
  logic [RowW-1:0] oy;
  logic [AW-1:0]   p_eff;
  logic            p_wrap;

  assign en         = !(out_valid_o && !out_ready_i);
  assign in_ready_o = en;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    is_pix   = (op_e'(op_i) == OP_PIXEL);
    start    = is_pix && (in_col_q == '0) && (in_row_q == '0);
    fd_eff   = start ? 1'b0 : fdone_q;
    ox       = start ? '0 : out_col_q;
    oy       = start ? '0 : out_row_q;
    col_wrap = ((WW+1)'(in_col_q) + 1'b1) >= (WW+1)'(w_eff);
    row_wrap = ((RowW+1)'(in_row_q) + 1'b1) >= (RowW+1)'(h_eff);
    // Pixel index row*W+col reaches W+1 without a multiply
    n_ge     = (in_row_q >= RowW'(2)) ||
               ((in_row_q == RowW'(1)) && (in_col_q != '0)) ||
               ((in_row_q == '0) && (in_col_q > w_eff));
    push     = is_pix || fdone_q;
    emit     = is_pix ? n_ge : fdone_q;
    at_top   = (oy == '0);
    at_left  = (ox == '0);
    at_right = ((WW+1)'(ox) + 1'b1) >= (WW+1)'(w_eff);
    at_bot   = ((RowW+1)'(oy) + 1'b1) >= (RowW+1)'(h_eff);
    last     = at_right && at_bot;
    p_eff    = ((WW+1)'(wp_q) >= (WW+1)'(w_eff)) ? '0 : wp_q;
    p_wrap   = ((WW+1)'(p_eff) + 1'b1) >= (WW+1)'(w_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      wp_q      <= '0;
      fdone_q   <= 1'b0;
    end else if (accept) begin
      if (is_pix) begin
        if (col_wrap) begin
          in_col_q <= '0;
          in_row_q <= row_wrap ? '0 : in_row_q + 1'b1;
        end else begin
          in_col_q <= in_col_q + 1'b1;
        end
      end
      if (emit) begin
        if (last) begin
          out_col_q <= '0;
          out_row_q <= '0;
        end else if (at_right) begin
          out_col_q <= '0;
          out_row_q <= oy + 1'b1;
        end else begin
          out_col_q <= ox + 1'b1;
          out_row_q <= oy;
        end
      end else begin
        out_col_q <= ox;
        out_row_q <= oy;
      end
      if (emit && last) begin
        fdone_q <= 1'b0;
      end else if (is_pix && col_wrap && row_wrap) begin
        fdone_q <= 1'b1;
      end else begin
        fdone_q <= fd_eff;
      end
      if (push) begin
        wp_q <= p_wrap ? '0 : p_eff + 1'b1;
      end
    end
  end

  // Window stage: line store data arrives, window shifts by one column
  logic            s1_v_q, s1_emit_q, s1_last_q, s1_fwd_q;
  logic            s1_top_q, s1_bot_q, s1_left_q, s1_right_q;
  logic [PixW-1:0] s1_pix_q, fa_q, fb_q, rd_a_q, rd_b_q;
  logic [AW-1:0]   s1_addr_q;
  logic [PixW-1:0] av, bv;

  logic [PixW-1:0] mem_a [MAX_WIDTH];
  logic [PixW-1:0] mem_b [MAX_WIDTH];

  // Forward the previous word's write when it hit the same entry as this read
  assign av = s1_fwd_q ? fa_q : rd_a_q;
  assign bv = s1_fwd_q ? fb_q : rd_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= accept && push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && push) begin
      s1_emit_q  <= emit;
      s1_last_q  <= last;
      s1_top_q   <= at_top;
      s1_bot_q   <= at_bot;
      s1_left_q  <= at_left;
      s1_right_q <= at_right;
      s1_pix_q   <= is_pix ? {red_in_i, green_in_i, blue_in_i} : '0;
      s1_addr_q  <= p_eff;
      s1_fwd_q   <= s1_v_q && (s1_addr_q == p_eff);
      fa_q       <= s1_pix_q;
      fb_q       <= av;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && push) begin
      rd_a_q <= mem_a[p_eff];
    end
    if (en && s1_v_q) begin
      mem_a[s1_addr_q] <= s1_pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && push) begin
      rd_b_q <= mem_b[p_eff];
    end
    if (en && s1_v_q) begin
      mem_b[s1_addr_q] <= av;
    end
  end

  pix9_t win_q, win_d, sel;
  logic [1:0] rs [3];
  logic [1:0] cs [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]     = win_q[r*3+1];
      win_d[r*3 + 1] = win_q[r*3+2];
    end
    win_d[2] = bv;
    win_d[5] = av;
    win_d[8] = s1_pix_q;
    // Clamp rows and columns at the frame edges
    rs[0] = s1_top_q   ? 2'd1 : 2'd0;
    rs[1] = 2'd1;
    rs[2] = s1_bot_q   ? 2'd1 : 2'd2;
    cs[0] = s1_left_q  ? 2'd1 : 2'd0;
    cs[1] = 2'd1;
    cs[2] = s1_right_q ? 2'd1 : 2'd2;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sel[i*3+j] = win_d[4'(rs[i]) * 4'd3 + 4'(cs[j])];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (en && s1_v_q) begin
      win_q <= win_d;
    end
  end

  // Tap chain: word k of the chain holds selected pixels and partial sums
  ctl_t  c_ctl [NumTaps+1];
  pix9_t c_pix [NumTaps+1];
  acc3_t c_acc [NumTaps+1];
  ctl_t  c0_ctl_q;
  pix9_t c0_pix_q;
  logic [47:0] krow [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_ctl_q <= '0;
    end else if (en) begin
      c0_ctl_q.vld  <= s1_v_q && s1_emit_q;
      c0_ctl_q.last <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c0_pix_q <= sel;
    end
  end

  assign c_ctl[0] = c0_ctl_q;
  assign c_pix[0] = c0_pix_q;
  assign c_acc[0] = {RoundHalf, RoundHalf, RoundHalf};
  assign krow[0]  = ktop_q;
  assign krow[1]  = kmid_q;
  assign krow[2]  = kbot_q;

  for (genvar k = 0; k < NumTaps; k++) begin : g_tap
    rcc_tap_cell #(
      .Idx (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .tap_i  ($signed(krow[k/3][16*(k%3) +: 16])),
      .ctl_i  (c_ctl[k]),
      .pix_i  (c_pix[k]),
      .acc_i  (c_acc[k]),
      .ctl_o  (c_ctl[k+1]),
      .pix_o  (c_pix[k+1]),
      .acc_o  (c_acc[k+1])
    );
  end

  // Round, shift and saturate into the output register
  logic [2:0][7:0] sat;

  always_comb begin
    logic [AccW-1:0] s;
    for (int ch = 0; ch < 3; ch++) begin
      s = c_acc[NumTaps][ch];
      if ($signed(s) <= 0) begin
        sat[ch] = 8'd0;
      end else if (s[AccW-1:FracBits] > (AccW-FracBits)'(255)) begin
        sat[ch] = 8'd255;
      end else begin
        sat[ch] = s[FracBits +: 8];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= c_ctl[NumTaps].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      red_out_o   <= sat[0];
      green_out_o <= sat[1];
      blue_out_o  <= sat[2];
      frame_end_o <= c_ctl[NumTaps].last;
    end
  end

endmodule

@@ rtl/rcc_checker.sv @@
// Port-level checks for the convolution core and their binding.
module rcc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] red_out_o,
  input logic       frame_end_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_out_o) && $stable(frame_end_o))
    else $error("stalled output word changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without an output stall");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  a_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind rgb_conv3x3_clamp_edge_core rcc_checker u_rcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .red_out_o   (red_out_o),
  .frame_end_o (frame_end_o)
);
